[sv/tdfp_pkg.sv]
// Shared types, codes and constants for the typed decimal field parser.
// No dependencies; used by the top level and its checker.
package tdfp_pkg;

	// Token length limits, in bytes, including the position that fails
	localparam int SHORT_TOKEN_BYTES = 8;
	localparam int LONG_TOKEN_BYTES  = 16;

	// Character counter width: holds up to LONG_TOKEN_BYTES-1
	localparam int CNT_W = $clog2(LONG_TOKEN_BYTES);

	localparam logic [CNT_W:0] SHORT_CAP = (CNT_W + 1)'(SHORT_TOKEN_BYTES);
	localparam logic [CNT_W:0] LONG_CAP  = (CNT_W + 1)'(LONG_TOKEN_BYTES);

	localparam int MAG_W = 17;
	localparam int VAL_W = 17;
	localparam int TMO_W = 32;

	localparam logic [MAG_W-1:0] MAG_CAP = MAG_W'(65536);
	localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(100000);

	// Transaction actions
	typedef enum logic [1:0] {
		ACT_START = 2'd0,
		ACT_DATA  = 2'd1,
		ACT_TICK  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	// Field types
	localparam logic [2:0] FT_INT8   = 3'd0;
	localparam logic [2:0] FT_UINT8  = 3'd1;
	localparam logic [2:0] FT_INT16  = 3'd2;
	localparam logic [2:0] FT_UINT16 = 3'd3;
	localparam logic [2:0] FT_BOOL   = 3'd4;

	// Result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_TIMEOUT = 3'd1,
		ST_COMMA   = 3'd2,
		ST_SYNTAX  = 3'd3,
		ST_RANGE   = 3'd4,
		ST_LONG    = 3'd5
	} status_t;

	// Number scan phases
	typedef enum logic [1:0] {
		PH_SPACE  = 2'd0,
		PH_SIGN   = 2'd1,
		PH_DIGITS = 2'd2,
		PH_BAD    = 2'd3
	} phase_t;

	// Special characters
	localparam logic [7:0] CH_CLOSE = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;

	localparam int TRUE_LEN  = 4;
	localparam int FALSE_LEN = 5;

	// Letters of "true" by position
	function automatic logic [7:0] true_char(input logic [CNT_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (pos)
			CNT_W'(0): c = 8'h74;
			CNT_W'(1): c = 8'h72;
			CNT_W'(2): c = 8'h75;
			CNT_W'(3): c = 8'h65;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

	// Letters of "false" by position
	function automatic logic [7:0] false_char(input logic [CNT_W-1:0] pos);
		logic [7:0] c;
		c = 8'h00;
		case (pos)
			CNT_W'(0): c = 8'h66;
			CNT_W'(1): c = 8'h61;
			CNT_W'(2): c = 8'h6C;
			CNT_W'(3): c = 8'h73;
			CNT_W'(4): c = 8'h65;
			default:   c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[sv/typed_decimal_field_parser.sv]
// Typed decimal field parser top level: input register, field state and result register.
// Depends on tdfp_pkg.
//
// Takes one transaction per cycle (start, data byte or timer tick) and gives at most one
// result per field: the parsed value or a failure status. A transaction is registered in the
// input register on acceptance; its state update and result are worked out from it and
// loaded into the field state and the result register. The rate is one transaction a
// cycle, set by the single per-byte update (multiply by ten, add and saturate) between the
// input register and the result register. Input stalls only while the result register holds
// an untaken result and the registered transaction would produce another. The user must
// write the timeout register through cfg_wr_en and cfg_wr_data only while the parser is
// idle; the block itself does not enforce this.
module typed_decimal_field_parser (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [tdfp_pkg::TMO_W-1:0]     cfg_wr_data,
	input  logic                           item_valid,
	output logic                           item_stall,
	input  logic [1:0]                     action,
	input  logic [2:0]                     field_type,
	input  logic [7:0]                     data_byte,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [2:0]                     status,
	output logic signed [tdfp_pkg::VAL_W-1:0] field_value
);

	localparam int CW = tdfp_pkg::CNT_W;
	localparam int MW = tdfp_pkg::MAG_W;
	localparam int VW = tdfp_pkg::VAL_W;
	localparam int TW = tdfp_pkg::TMO_W;

	// Input register
	logic                valid_s1;
	tdfp_pkg::action_t   action_s1;
	logic [2:0]          type_s1;
	logic [7:0]          byte_s1;

	// Field state
	logic [TW-1:0]       timeout_q;
	logic                active_q;
	logic [2:0]          type_q;
	tdfp_pkg::phase_t    phase_q;
	logic                neg_q;
	logic [MW-1:0]       mag_q;
	logic                digit_q;
	logic [CW-1:0]       count_q;
	logic [1:0]          match_q;
	logic [TW-1:0]       idle_q;

	// Next state and result
	logic                active_d;
	logic [2:0]          type_d;
	tdfp_pkg::phase_t    phase_d;
	logic                neg_d;
	logic [MW-1:0]       mag_d;
	logic                digit_d;
	logic [CW-1:0]       count_d;
	logic [1:0]          match_d;
	logic [TW-1:0]       idle_d;
	logic                res_hit;
	tdfp_pkg::status_t   res_status;
	logic [VW-1:0]       res_value;

	// Result register
	logic                out_valid_q;
	tdfp_pkg::status_t   out_status_q;
	logic [VW-1:0]       out_value_q;

	logic                advance;

	// Helpers for the registered byte
	logic                is_space;
	logic                is_digit;
	logic                is_long;
	logic [CW:0]         cap;
	logic [CW:0]         count_inc;
	logic [MW+3:0]       mag_mul;
	logic [MW-1:0]       pos_max;
	logic [MW-1:0]       neg_max;
	logic                is_unsigned;

	assign is_space = (byte_s1 == tdfp_pkg::CH_SPACE) ||
		(byte_s1 >= tdfp_pkg::CH_TAB && byte_s1 <= tdfp_pkg::CH_CR);
	assign is_digit = (byte_s1 >= tdfp_pkg::CH_ZERO) && (byte_s1 <= tdfp_pkg::CH_NINE);
	assign is_long  = (type_q == tdfp_pkg::FT_INT16) || (type_q == tdfp_pkg::FT_UINT16);
	assign cap      = is_long ? tdfp_pkg::LONG_CAP : tdfp_pkg::SHORT_CAP;
	assign count_inc = {1'b0, count_q} + (CW + 1)'(1);
	// Ten times the magnitude plus the digit
	assign mag_mul  = {3'b000, mag_q, 1'b0} + {1'b0, mag_q, 3'b000} +
		(MW + 4)'(byte_s1 - tdfp_pkg::CH_ZERO);
	assign is_unsigned = (type_q == tdfp_pkg::FT_UINT8) || (type_q == tdfp_pkg::FT_UINT16);

	// Range limits of the active type
	always_comb begin
		pos_max = MW'(127);
		neg_max = MW'(128);
		case (type_q)
			tdfp_pkg::FT_UINT8:  pos_max = MW'(255);
			tdfp_pkg::FT_INT16: begin
				pos_max = MW'(32767);
				neg_max = MW'(32768);
			end
			tdfp_pkg::FT_UINT16: pos_max = MW'(65535);
			default:             pos_max = MW'(127);
		endcase
		if (is_unsigned) begin
			neg_max = '0;
		end
	end

	// Work out the state update and result of the registered transaction
	always_comb begin
		active_d   = active_q;
		type_d     = type_q;
		phase_d    = phase_q;
		neg_d      = neg_q;
		mag_d      = mag_q;
		digit_d    = digit_q;
		count_d    = count_q;
		match_d    = match_q;
		idle_d     = idle_q;
		res_hit    = 1'b0;
		res_status = tdfp_pkg::ST_OK;
		res_value  = '0;

		case (action_s1)
			tdfp_pkg::ACT_START: begin
				if (type_s1 <= tdfp_pkg::FT_BOOL) begin
					active_d = 1'b1;
					type_d   = type_s1;
					phase_d  = tdfp_pkg::PH_SPACE;
					neg_d    = 1'b0;
					mag_d    = '0;
					digit_d  = 1'b0;
					count_d  = '0;
					match_d  = 2'b11;
					idle_d   = '0;
				end
			end
			tdfp_pkg::ACT_TICK: begin
				if (active_q) begin
					if (idle_q != '1) begin
						idle_d = idle_q + TW'(1);
					end
					if (idle_d >= timeout_q) begin
						res_hit    = 1'b1;
						res_status = tdfp_pkg::ST_TIMEOUT;
					end
				end
			end
			tdfp_pkg::ACT_DATA: begin
				if (active_q) begin
					idle_d = '0;
					if (byte_s1 == tdfp_pkg::CH_CLOSE) begin
						// Close the field
						res_hit = 1'b1;
						if (type_q == tdfp_pkg::FT_BOOL) begin
							if (match_q[0] && count_q == CW'(tdfp_pkg::TRUE_LEN)) begin
								res_value = VW'(1);
							end else if (match_q[1] &&
									count_q == CW'(tdfp_pkg::FALSE_LEN)) begin
								res_value = '0;
							end else begin
								res_status = tdfp_pkg::ST_SYNTAX;
							end
						end else if (phase_q != tdfp_pkg::PH_DIGITS || !digit_q) begin
							res_status = tdfp_pkg::ST_SYNTAX;
						end else if (neg_q) begin
							if (mag_q > neg_max) begin
								res_status = tdfp_pkg::ST_RANGE;
							end else begin
								res_value = VW'(0) - VW'(mag_q);
							end
						end else if (mag_q > pos_max) begin
							res_status = tdfp_pkg::ST_RANGE;
						end else begin
							res_value = VW'(mag_q);
						end
					end else if (byte_s1 == tdfp_pkg::CH_COMMA) begin
						res_hit    = 1'b1;
						res_status = tdfp_pkg::ST_COMMA;
					end else if (count_inc >= cap) begin
						res_hit    = 1'b1;
						res_status = tdfp_pkg::ST_LONG;
					end else begin
						count_d = count_q + CW'(1);
						if (type_q == tdfp_pkg::FT_BOOL) begin
							// Drop the words that no longer match
							if (count_q >= CW'(tdfp_pkg::TRUE_LEN) ||
									tdfp_pkg::true_char(count_q) != byte_s1) begin
								match_d[0] = 1'b0;
							end
							if (count_q >= CW'(tdfp_pkg::FALSE_LEN) ||
									tdfp_pkg::false_char(count_q) != byte_s1) begin
								match_d[1] = 1'b0;
							end
						end else if (phase_q == tdfp_pkg::PH_SPACE && is_space) begin
							phase_d = tdfp_pkg::PH_SPACE;
						end else if (phase_q == tdfp_pkg::PH_SPACE &&
								(byte_s1 == tdfp_pkg::CH_PLUS ||
								byte_s1 == tdfp_pkg::CH_MINUS)) begin
							neg_d   = (byte_s1 == tdfp_pkg::CH_MINUS);
							phase_d = tdfp_pkg::PH_SIGN;
						end else if (phase_q != tdfp_pkg::PH_BAD && is_digit) begin
							mag_d   = (mag_mul > (MW + 4)'(tdfp_pkg::MAG_CAP)) ?
								tdfp_pkg::MAG_CAP : mag_mul[MW-1:0];
							digit_d = 1'b1;
							phase_d = tdfp_pkg::PH_DIGITS;
						end else begin
							phase_d = tdfp_pkg::PH_BAD;
						end
					end
				end
			end
			default: begin
				active_d = active_q;
			end
		endcase

		// A result ends the field
		if (res_hit) begin
			active_d = 1'b0;
		end
	end

	// Advance the registered transaction unless its result has nowhere to go
	assign advance    = valid_s1 && !(res_hit && out_valid_q && result_stall);
	assign item_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall) begin
			action_s1 <= tdfp_pkg::action_t'(action);
			type_s1   <= field_type;
			byte_s1   <= data_byte;
		end
	end

	// Timeout register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= tdfp_pkg::TIMEOUT_RESET;
		end else if (cfg_wr_en) begin
			timeout_q <= cfg_wr_data;
		end
	end

	// Field state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			type_q   <= tdfp_pkg::FT_INT8;
			phase_q  <= tdfp_pkg::PH_SPACE;
			neg_q    <= 1'b0;
			mag_q    <= '0;
			digit_q  <= 1'b0;
			count_q  <= '0;
			match_q  <= 2'b11;
			idle_q   <= '0;
		end else if (advance) begin
			active_q <= active_d;
			type_q   <= type_d;
			phase_q  <= phase_d;
			neg_q    <= neg_d;
			mag_q    <= mag_d;
			digit_q  <= digit_d;
			count_q  <= count_d;
			match_q  <= match_d;
			idle_q   <= idle_d;
		end
	end

	// Result register: load a new result, or drop one that was taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_hit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_hit) begin
			out_status_q <= res_status;
			out_value_q  <= res_value;
		end
	end

	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign field_value  = $signed(out_value_q);

endmodule

[sv/tdfp_checker.sv]
// Port-level checks for the typed decimal field parser, with the bind that attaches them.
// Depends on tdfp_pkg and typed_decimal_field_parser.
module tdfp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            item_valid,
	input logic                            item_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input logic [2:0]                      status,
	input logic signed [tdfp_pkg::VAL_W-1:0] field_value
);

	logic item_accept;
	assign item_accept = item_valid && !item_stall;

	// Hold a stalled result
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status) &&
		$stable(field_value))
		else $error("stalled result changed");

	// Input stalls only behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> result_valid && result_stall)
		else $error("input stalled with result path free");

	// Failures carry a zero value
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != tdfp_pkg::ST_OK |-> field_value == '0)
		else $error("non-zero value on failure");

	// No result appears in an empty result register without an accepted transaction ahead of it
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid && !item_accept && !$past(item_accept) |=> !result_valid)
		else $error("result without a transaction");

endmodule

bind typed_decimal_field_parser tdfp_checker u_tdfp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.status       (status),
	.field_value  (field_value)
);
